/* src/radiotap_antenna_signal_extract_defines.svh */
// assertion helpers shared by the radiotap extractor
`ifndef RADIOTAP_ANTENNA_SIGNAL_EXTRACT_DEFINES_SVH
`define RADIOTAP_ANTENNA_SIGNAL_EXTRACT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RASX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasx same-cycle check failed");

// next-cycle implication, checked out of reset
`define RASX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasx next-cycle check failed");

`endif

/* src/rasx_pkg.sv */
package rasx_pkg;

  localparam int unsigned POS_W = 16;

  // fixed header layout
  localparam logic [POS_W-1:0] FIRST_WORD_POS = 16'd4;
  localparam logic [POS_W-1:0] CHAIN_MIN_POS  = 16'd7;
  localparam int unsigned      CHAIN_BIT      = 7;
  localparam int unsigned      SIGNAL_BIT     = 5;

  // present bits ahead of antenna signal
  localparam int unsigned TSFT_BIT    = 0;
  localparam int unsigned FLAGS_BIT   = 1;
  localparam int unsigned RATE_BIT    = 2;
  localparam int unsigned CHANNEL_BIT = 3;
  localparam int unsigned FHSS_BIT    = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              signal_valid;
    logic signed [7:0] signal_dbm;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             chain_open;
  } parse_stat_t;

endpackage

/* src/rasx_if.sv */
interface rasx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rasx_result_if;
  logic              valid;
  logic              ready;
  logic              signal_valid;
  logic signed [7:0] signal_dbm;

  modport source (output valid, output signal_valid, output signal_dbm, input ready);
  modport sink   (input valid, input signal_valid, input signal_dbm, output ready);
endinterface

/* src/rasx_sig_offset.sv */
module rasx_sig_offset import rasx_pkg::*; (
  input  logic [POS_W-1:0] start,
  input  logic [5:0]       bits,
  output logic [POS_W-1:0] offset
);

  logic [POS_W:0] t0, t1, t2, t3, t4, t5;

  always_comb begin
    t0 = {1'b0, start};
    // tsft: 8 bytes, 8-aligned
    t1 = bits[TSFT_BIT] ? (((t0 + (POS_W+1)'(7)) & ~(POS_W+1)'(7)) + (POS_W+1)'(8)) : t0;
    t2 = bits[FLAGS_BIT] ? (t1 + (POS_W+1)'(1)) : t1;
    t3 = bits[RATE_BIT] ? (t2 + (POS_W+1)'(1)) : t2;
    // channel: 4 bytes, 2-aligned
    t4 = bits[CHANNEL_BIT] ? (((t3 + (POS_W+1)'(1)) & ~(POS_W+1)'(1)) + (POS_W+1)'(4)) : t3;
    // fhss: 2 bytes, 2-aligned
    t5 = bits[FHSS_BIT] ? (((t4 + (POS_W+1)'(1)) & ~(POS_W+1)'(1)) + (POS_W+1)'(2)) : t4;
    offset = t5[POS_W] ? '1 : t5[POS_W-1:0];
  end

endmodule

/* src/rasx_parse.sv */
module rasx_parse import rasx_pkg::*; #(
  parameter int unsigned MIN_LENGTH = 8,
  parameter int unsigned MAX_BYTES  = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  output result_t     res,
  output parse_stat_t stat
);

  localparam logic [POS_W-1:0] MIN_POS = POS_W'(MIN_LENGTH - 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       fw_r, fw_nxt;
  logic             chain_r, chain_nxt;
  logic [POS_W-1:0] tgt_r, tgt_nxt;
  logic             tk_r, tk_nxt;
  logic             hb_r, hb_nxt;
  logic             seen_r, seen_nxt;
  logic [7:0]       val_r, val_nxt;

  logic             active;
  logic             chain_end;
  logic [POS_W-1:0] start;
  logic [POS_W-1:0] sig_off;
  logic             ok;

  rasx_sig_offset u_off (
    .start  (start),
    .bits   (fw_r),
    .offset (sig_off)
  );

  always_comb begin
    active    = pos_r < MAX_POS;
    start     = pos_r + POS_W'(1);
    hb_nxt    = hb_r | (active && pos_r == '0 && item.data_byte != 8'd0);
    fw_nxt    = (active && pos_r == FIRST_WORD_POS) ? item.data_byte[5:0] : fw_r;
    chain_end = active && chain_r && pos_r >= CHAIN_MIN_POS && pos_r[1:0] == 2'b11
                && !item.data_byte[CHAIN_BIT];
    chain_nxt = chain_r & ~chain_end;
    tk_nxt    = tk_r;
    tgt_nxt   = tgt_r;
    if (chain_end && fw_r[SIGNAL_BIT]) begin
      tk_nxt  = 1'b1;
      tgt_nxt = sig_off;
    end
    seen_nxt = seen_r;
    val_nxt  = val_r;
    if (active && tk_r && !seen_r && pos_r == tgt_r) begin
      seen_nxt = 1'b1;
      val_nxt  = item.data_byte;
    end
    pos_nxt = active ? start : pos_r;

    ok = !hb_nxt && !chain_nxt && tk_nxt && seen_nxt && pos_r >= MIN_POS;
    res.signal_valid = ok;
    res.signal_dbm   = ok ? $signed(val_nxt) : 8'sd0;

    stat.pos        = pos_r;
    stat.chain_open = chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fw_r    <= '0;
      chain_r <= 1'b1;
      tgt_r   <= '0;
      tk_r    <= 1'b0;
      hb_r    <= 1'b0;
      seen_r  <= 1'b0;
      val_r   <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        // packet done, start over
        pos_r   <= '0;
        fw_r    <= '0;
        chain_r <= 1'b1;
        tgt_r   <= '0;
        tk_r    <= 1'b0;
        hb_r    <= 1'b0;
        seen_r  <= 1'b0;
        val_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        fw_r    <= fw_nxt;
        chain_r <= chain_nxt;
        tgt_r   <= tgt_nxt;
        tk_r    <= tk_nxt;
        hb_r    <= hb_nxt;
        seen_r  <= seen_nxt;
        val_r   <= val_nxt;
      end
    end
  end

endmodule

/* src/radiotap_antenna_signal_extract.sv */
// radiotap antenna signal extractor
// in_bus carries a captured radiotap buffer one byte per request, offset 0 first,
// with last_byte set on the final byte. out_bus gives exactly one request per
// buffer, after its last byte: signal_valid and the signed dBm value (0 if not
// valid).
// throughput: one byte per cycle unless a last byte is held for a full output
// register (see below). the per-byte work is one compare and add stage between
// the input register and the parser state.
// a byte enters the input register when it is accepted; when a last byte steps
// the parser, its result is loaded into the output register, which drives out_bus.
// when the receiver stalls, the result waits in the output register; bytes of
// the next buffer keep flowing until another last byte reaches the parser with
// the output register still full, which then holds the input register and
// drops in_bus.ready.
// reset (rst_n low, synchronous) empties both registers and returns the parser
// to offset 0 with the present chain open; the parser is cleared the same way
// after every last byte. the byte counter saturates at MAX_BYTES.
`include "radiotap_antenna_signal_extract_defines.svh"

module radiotap_antenna_signal_extract import rasx_pkg::*; #(
  parameter int unsigned MIN_LENGTH = 8,
  parameter int unsigned MAX_BYTES  = 65535
) (
  input  logic          clk,
  input  logic          rst_n,
  rasx_byte_if.sink     in_bus,
  rasx_result_if.source out_bus
);

  // input register
  logic        s1_v_r;
  in_item_t    s1_item_r;
  logic        s1_fire;

  // output register
  logic        out_v_r;
  result_t     out_res_r;

  result_t     res;
  parse_stat_t stat;

  // parser steps unless a last byte would overwrite a pending result
  assign s1_fire      = s1_v_r && (!s1_item_r.last_byte || !out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_item_r.data_byte <= in_bus.data_byte;
      s1_item_r.last_byte <= in_bus.last_byte;
    end
  end

  rasx_parse #(
    .MIN_LENGTH (MIN_LENGTH),
    .MAX_BYTES  (MAX_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_fire),
    .item  (s1_item_r),
    .res   (res),
    .stat  (stat)
  );

  // result register: loads on a last byte, empties when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && s1_item_r.last_byte) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.last_byte) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.signal_valid = out_res_r.signal_valid;
  assign out_bus.signal_dbm   = out_res_r.signal_dbm;

  // invalid results carry a zero value
  `RASX_ASSERT_NOW(a_zero_when_invalid, out_v_r && !out_res_r.signal_valid, out_res_r.signal_dbm == 8'sd0)
  // backpressure only with a held byte in the input register
  `RASX_ASSERT_NOW(a_stall_has_item, !in_bus.ready, s1_v_r && s1_item_r.last_byte && out_v_r)
  // parser restarts after every last byte
  `RASX_ASSERT_NEXT(a_restart, s1_fire && s1_item_r.last_byte, stat.pos == '0 && stat.chain_open)
  // a last byte always leaves a result behind
  `RASX_ASSERT_NEXT(a_result_loaded, s1_fire && s1_item_r.last_byte, out_v_r)

endmodule
